// File: sv/tssi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tssi_pkg;

  localparam int unsigned VAL_W  = 64;
  localparam int unsigned TOL_W  = 32;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned RIDX_W = 6;
  localparam int unsigned POS_W  = 7;

  localparam logic [TOL_W-1:0] TOL_RESET = 32'd4295;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_SRCH = 3'b100
  } state_e;

endpackage

`default_nettype wire

// File: sv/tssi_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module tssi_cell
  import tssi_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  wire logic             clk_i,
  input  wire logic [VAL_W-1:0] prev_i,
  input  wire logic [VAL_W-1:0] key_i,
  input  wire logic [TOL_W-1:0] tol_i,
  input  wire logic             ins_i,
  input  wire logic [CW-1:0]    where_i,
  input  wire logic [CW-1:0]    count_i,
  output logic      [VAL_W-1:0] value_o,
  output logic                  lt_o,
  output logic                  match_o
);

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic [VAL_W-1:0] value_q, value_d;
  logic             lt_q, lt_d;
  logic             match_q, match_d;
  logic [VAL_W-1:0] mag;

  always_comb begin
    value_d = value_q;
    if (ins_i && (MyIdx == where_i)) begin
      value_d = key_i;
    end else if (ins_i && (MyIdx > where_i) && (MyIdx <= count_i)) begin
      value_d = prev_i;
    end
  end

  always_comb begin
    lt_d    = $signed(value_q) < $signed(key_i);
    // two's-complement difference is the exact magnitude as an unsigned word
    mag     = lt_d ? (key_i - value_q) : (value_q - key_i);
    match_d = mag < {{(VAL_W-TOL_W){1'b0}}, tol_i};
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    lt_q    <= lt_d;
    match_q <= match_d;
  end

  assign value_o = value_q;
  assign lt_o    = lt_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

// File: sv/tolerant_sorted_set_insert.sv
// Sorted set of signed Q32.32 values held in a row of DEPTH cells. An insert
// first has every cell compare its entry against the key, then runs the
// halving-search probes over the registered compare bits, plus a closing
// step when nothing matches; the cells shift up on the result edge. Read,
// clear and unused requests finish without leaving the idle state. busy_o
// is high while an insert is in progress and low in the cycle done_o is
// high, so a new start can be taken there. done_o marks each result for
// exactly one cycle; the receiver has no way to stall it and must take
// every beat.
`timescale 1ns / 1ps
`default_nettype none

module tolerant_sorted_set_insert
  import tssi_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic        [TOL_W-1:0] cfg_data_i,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic        [REQ_W-1:0] req_type_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire logic       [RIDX_W-1:0] read_index_i,
  output logic                         done_o,
  output logic                         found_o,
  output logic                         inserted_o,
  output logic             [POS_W-1:0] position_o,
  output logic                         full_res_o,
  output logic             [POS_W-1:0] entry_count_o,
  output logic signed      [VAL_W-1:0] read_value_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > RIDX_W) ? CW : RIDX_W;
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  state_e           state_q, state_d;
  logic [TOL_W-1:0] tol_q;
  logic [VAL_W-1:0] key_q;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    lo_q, lo_d;
  logic [CW-1:0]    len_q, len_d;
  logic [CW-1:0]    mid;

  logic             done_q, done_d;
  logic             found_q, found_d;
  logic             ins_q, ins_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic             full_q, full_d;
  logic [VAL_W-1:0] rval_q, rval_d;

  logic             do_ins;
  logic [VAL_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0] cell_lt;
  logic [DEPTH-1:0] cell_match;

  logic             accept;
  logic [XW-1:0]    ridx_x;
  logic             rd_hit;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] prev;
    if (i == 0) begin : g_head
      assign prev = key_q;
    end else begin : g_link
      assign prev = cell_val[i-1];
    end
    tssi_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .prev_i  (prev),
      .key_i   (key_q),
      .tol_i   (tol_q),
      .ins_i   (do_ins),
      .where_i (lo_q),
      .count_i (count_q),
      .value_o (cell_val[i]),
      .lt_o    (cell_lt[i]),
      .match_o (cell_match[i])
    );
  end

  assign accept = start_i && !busy_o;
  assign mid    = lo_q + (len_q >> 1);
  assign ridx_x = XW'(read_index_i);
  assign rd_hit = ridx_x < XW'(count_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    lo_d    = lo_q;
    len_d   = len_q;
    done_d  = 1'b0;
    found_d = found_q;
    ins_d   = ins_q;
    pos_d   = pos_q;
    full_d  = full_q;
    rval_d  = rval_q;
    do_ins  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          found_d = 1'b0;
          ins_d   = 1'b0;
          pos_d   = '0;
          full_d  = 1'b0;
          rval_d  = '0;
          lo_d    = '0;
          len_d   = count_q;
          case (req_type_i)
            REQ_INSERT: state_d = S_CMP;
            REQ_READ: begin
              done_d = 1'b1;
              if (rd_hit) begin
                rval_d = cell_val[ridx_x[AW-1:0]];
              end
            end
            REQ_CLEAR: begin
              done_d  = 1'b1;
              count_d = '0;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_CMP: state_d = S_SRCH;
      S_SRCH: begin
        if (len_q == '0) begin
          // no entry within tolerance: lo_q is the sorted position
          state_d = S_IDLE;
          done_d  = 1'b1;
          pos_d   = lo_q;
          if (count_q == Full) begin
            full_d = 1'b1;
          end else begin
            do_ins  = 1'b1;
            ins_d   = 1'b1;
            count_d = count_q + 1'b1;
          end
        end else if (cell_match[mid[AW-1:0]]) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          found_d = 1'b1;
          pos_d   = mid;
        end else if (cell_lt[mid[AW-1:0]]) begin
          lo_d  = mid + 1'b1;
          len_d = (len_q - 1'b1) >> 1;
        end else begin
          len_d = len_q >> 1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      tol_q   <= TOL_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    len_q   <= len_d;
    found_q <= found_d;
    ins_q   <= ins_d;
    pos_q   <= pos_d;
    full_q  <= full_d;
    rval_q  <= rval_d;
    if (accept) begin
      key_q <= value_i;
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign found_o       = found_q;
  assign inserted_o    = ins_q;
  assign position_o    = POS_W'(pos_q);
  assign full_res_o    = full_q;
  assign entry_count_o = POS_W'(count_q);
  assign read_value_o  = $signed(rval_q);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count above depth");

  a_ins_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && inserted_o) |-> (!found_o && !full_res_o))
    else $error("insert reported together with match or full");

  a_ins_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && inserted_o) |-> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow the store by one");

  a_ins_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == REQ_INSERT)) |=> (busy_o && !done_o))
    else $error("insert start did not enter the search");

endmodule

`default_nettype wire

// File: bench/tb_tolerant_sorted_set_insert.sv
`timescale 1ns / 1ps

module tb_tolerant_sorted_set_insert;
  import tssi_pkg::*;

  localparam int unsigned SET_DEPTH = 64;

  typedef struct {
    logic                    found;
    logic                    inserted;
    logic        [POS_W-1:0] position;
    logic                    full;
    logic        [POS_W-1:0] count;
    logic signed [VAL_W-1:0] rvalue;
  } set_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic        [TOL_W-1:0]  cfg_data_i = '0;
  logic                     start_i = 1'b0;
  logic        [REQ_W-1:0]  req_type_i = REQ_NONE;
  logic signed [VAL_W-1:0]  value_i = '0;
  logic        [RIDX_W-1:0] read_index_i = '0;
  logic                     busy_o;
  logic                     done_o;
  logic                     found_o;
  logic                     inserted_o;
  logic        [POS_W-1:0]  position_o;
  logic                     full_res_o;
  logic        [POS_W-1:0]  entry_count_o;
  logic signed [VAL_W-1:0]  read_value_o;

  // shadow copy of the set, its fill level and the match tolerance
  logic signed [VAL_W-1:0]  shadow_set [SET_DEPTH];
  int unsigned              shadow_count = 0;
  logic        [TOL_W-1:0]  shadow_tol = TOL_RESET;

  set_result_t              pending_results [$];
  set_result_t              oldest;
  int                       mismatch_count = 0;
  bit                       gaps_on = 1'b1;

  tolerant_sorted_set_insert #(
    .DEPTH(SET_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .read_index_i (read_index_i),
    .done_o       (done_o),
    .found_o      (found_o),
    .inserted_o   (inserted_o),
    .position_o   (position_o),
    .full_res_o   (full_res_o),
    .entry_count_o(entry_count_o),
    .read_value_o (read_value_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [VAL_W-1:0] distance(logic signed [VAL_W-1:0] a,
                                                 logic signed [VAL_W-1:0] b);
    return (a < b) ? b - a : a - b;
  endfunction

  // Updates the shadow set for one accepted request and builds its result.
  function automatic void apply_request(req_e kind, logic signed [VAL_W-1:0] key,
                                        logic [RIDX_W-1:0] idx,
                                        output set_result_t res);
    int unsigned lo;
    int unsigned len;
    int unsigned mid;
    int unsigned where;
    bit          hit;
    res = '{default: '0};
    lo = 0;
    len = shadow_count;
    hit = 1'b0;
    where = 0;
    case (kind)
      REQ_INSERT: begin
        // halving search, the probe path decides which match is reported
        while (len > 0 && !hit) begin
          mid = lo + len / 2;
          if (distance(shadow_set[mid], key) < {32'b0, shadow_tol}) begin
            hit = 1'b1;
            where = mid;
          end else if (shadow_set[mid] < key) begin
            lo = mid + 1;
            len = (len - 1) / 2;
          end else begin
            len = len / 2;
          end
        end
        if (!hit) where = lo;
        if (hit) begin
          res.found = 1'b1;
        end else if (shadow_count >= SET_DEPTH) begin
          res.full = 1'b1;
        end else begin
          for (int unsigned i = shadow_count; i > where; i--)
            shadow_set[i] = shadow_set[i-1];
          shadow_set[where] = key;
          shadow_count++;
          res.inserted = 1'b1;
        end
        res.position = where[POS_W-1:0];
      end
      REQ_READ: begin
        if (idx < shadow_count) res.rvalue = shadow_set[idx];
      end
      REQ_CLEAR: begin
        shadow_count = 0;
      end
      default: ;
    endcase
    res.count = shadow_count[POS_W-1:0];
  endfunction

  task automatic report_mismatch(string field, logic [VAL_W-1:0] got,
                                 logic [VAL_W-1:0] want);
    if (mismatch_count < 40)
      $display("MISMATCH %s: got %0h expected %0h at %0t", field, got, want, $realtime);
    mismatch_count++;
  endtask

  // results cannot be stalled, so every done beat is checked on its edge
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        oldest = pending_results.pop_front();
        if (found_o !== oldest.found)
          report_mismatch("found", VAL_W'(found_o), VAL_W'(oldest.found));
        if (inserted_o !== oldest.inserted)
          report_mismatch("inserted", VAL_W'(inserted_o), VAL_W'(oldest.inserted));
        if (position_o !== oldest.position)
          report_mismatch("position", VAL_W'(position_o), VAL_W'(oldest.position));
        if (full_res_o !== oldest.full)
          report_mismatch("full_res", VAL_W'(full_res_o), VAL_W'(oldest.full));
        if (entry_count_o !== oldest.count)
          report_mismatch("entry_count", VAL_W'(entry_count_o), VAL_W'(oldest.count));
        if (read_value_o !== oldest.rvalue)
          report_mismatch("read_value", read_value_o, oldest.rvalue);
      end
    end
  end

  task automatic send_req(req_e kind, logic signed [VAL_W-1:0] val,
                          logic [RIDX_W-1:0] idx);
    set_result_t want;
    int          gap;
    if (gaps_on && $urandom_range(99) < 16) begin
      start_i <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    req_type_i   <= kind;
    value_i      <= val;
    read_index_i <= idx;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    apply_request(kind, val, idx, want);
    pending_results.push_back(want);
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] tol);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= tol;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    shadow_tol = tol;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] r;
    logic [VAL_W-1:0] span;
    int               sel;
    int               ipart;
    r = {$urandom, $urandom};
    sel = $urandom_range(9);
    if (sel < 4 && shadow_count > 0) begin
      // near an existing entry: hits, misses just past the tolerance edge
      span = 2 * {32'b0, shadow_tol} + 3;
      return shadow_set[$urandom_range(0, shadow_count - 1)] + (r % span)
             - {32'b0, shadow_tol} - 1;
    end
    if (sel == 4) begin
      case ($urandom_range(3))
        0: return {1'b1, 63'b0};
        1: return {1'b0, {63{1'b1}}};
        2: return '0;
        default: return '1;
      endcase
    end
    if (sel < 8) begin
      ipart = int'($urandom_range(0, 64)) - 32;
      return {ipart, $urandom};
    end
    return r;
  endfunction

  task automatic test_empty_and_extremes();
    send_req(REQ_READ, {$urandom, $urandom}, 6'd0);
    send_req(REQ_NONE, {$urandom, $urandom}, 6'h3f);
    send_req(REQ_INSERT, 64'sd0, 6'd0);
    send_req(REQ_INSERT, {1'b0, {63{1'b1}}}, 6'h2a);
    send_req(REQ_INSERT, {1'b1, 63'b0}, 6'h15);
    send_req(REQ_INSERT, 64'sd4294, 6'd0);
    send_req(REQ_INSERT, 64'sd4295, 6'd0);
    send_req(REQ_INSERT, -64'sd4295, 6'd0);
    send_req(REQ_INSERT, -64'sd4294, 6'd0);
    for (int i = 0; i < 6; i++) send_req(REQ_READ, '0, i[RIDX_W-1:0]);
    send_req(REQ_READ, '1, 6'h3f);
    send_req(REQ_CLEAR, '1, 6'h3f);
    send_req(REQ_READ, '0, 6'd0);
    send_req(REQ_NONE, '0, 6'd0);
  endtask

  task automatic test_tolerance_extremes();
    write_tolerance('0);
    send_req(REQ_INSERT, 64'sd5, 6'd0);
    send_req(REQ_INSERT, 64'sd5, 6'd0);
    send_req(REQ_INSERT, -64'sd1, 6'd0);
    send_req(REQ_INSERT, -64'sd1, 6'd0);
    send_req(REQ_READ, '0, 6'd2);
    send_req(REQ_CLEAR, '0, 6'd0);
    // widest distance between the two ends must not wrap into a match
    write_tolerance('1);
    send_req(REQ_INSERT, {1'b1, 63'b0}, 6'd0);
    send_req(REQ_INSERT, {1'b0, {63{1'b1}}}, 6'd0);
    send_req(REQ_INSERT, {1'b0, {63{1'b1}}} - 64'sh0_FFFF_FFFE, 6'd0);
    send_req(REQ_INSERT, {1'b1, 63'b0} + 64'sh0_FFFF_FFFF, 6'd0);
    send_req(REQ_READ, '0, 6'd1);
    send_req(REQ_CLEAR, '0, 6'd0);
  endtask

  task automatic test_full_store();
    int order [SET_DEPTH];
    int j;
    int tmp;
    write_tolerance(TOL_RESET);
    for (int i = 0; i < SET_DEPTH; i++) order[i] = i;
    for (int i = SET_DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < SET_DEPTH; i++)
      send_req(REQ_INSERT, longint'(order[i] - 32) <<< 34,
               RIDX_W'($urandom_range(0, 63)));
    send_req(REQ_INSERT, (longint'(5) <<< 34) + (longint'(1) <<< 33), 6'd0);
    send_req(REQ_INSERT, (longint'(3) <<< 34) + 100, 6'd0);
    send_req(REQ_INSERT, {1'b0, {63{1'b1}}}, 6'd0);
    send_req(REQ_INSERT, {1'b1, 63'b0}, 6'd0);
    send_req(REQ_READ, '0, 6'd63);
    send_req(REQ_READ, '0, 6'd0);
    send_req(REQ_CLEAR, '0, 6'd0);
  endtask

  task automatic run_random(int n, int clear_pct, bit idle_gaps);
    int               pick;
    logic [RIDX_W-1:0] idx;
    gaps_on = idle_gaps;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && clear_pct == 0) wait_idle();
      pick = $urandom_range(99);
      if (shadow_count > 0 && $urandom_range(3) != 0)
        idx = RIDX_W'($urandom_range(0, shadow_count - 1));
      else
        idx = RIDX_W'($urandom_range(0, 63));
      if (pick < 72)
        send_req(REQ_INSERT, pick_value(), idx);
      else if (pick < 72 + clear_pct)
        send_req(REQ_CLEAR, pick_value(), idx);
      else if (pick < 75 + clear_pct)
        send_req(REQ_NONE, pick_value(), idx);
      else
        send_req(REQ_READ, {$urandom, $urandom}, idx);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    write_tolerance($urandom);
    run_random(260, 1, 1'b1);
    write_tolerance(32'd1);
    run_random(260, 0, 1'b1);
    write_tolerance('1);
    run_random(260, 1, 1'b0);
    write_tolerance('0);
    run_random(260, 2, 1'b1);
    write_tolerance(TOL_RESET);
    run_random(260, 1, 1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_extremes();
    test_tolerance_extremes();
    test_full_store();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/tssi_pkg.sv
sv/tssi_cell.sv
sv/tolerant_sorted_set_insert.sv
bench/tb_tolerant_sorted_set_insert.sv
